### sv/assert_macros.svh
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define LQSF_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Antecedent at one edge implies consequent at the next edge.
`define LQSF_ASSERT_NEXT(lbl, clk, rst, pre, post, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

### sv/lqsf_pkg.sv
// Package: constants and types of the linear-quadratic survival fit.
`timescale 1ns / 1ps
package lqsf_pkg;

   localparam int MAX_POINTS_DEF = 64;
   localparam int SUM_W          = 64;
   localparam int WIDE_W         = 128;
   localparam int OUT_W          = 24;
   localparam int DOSE_W         = 13;
   localparam int SF_W           = 17;
   localparam int Y_W            = 20;

   // 1e-10 in Q.48
   localparam logic [WIDE_W-1:0] DET_EPS = WIDE_W'(28148);
   // ln(2) in Q0.32
   localparam logic [31:0]       LN2_Q32 = 32'd2977044472;
   localparam logic [OUT_W-1:0]  OUT_MAX = {OUT_W{1'b1}};

   typedef enum logic [1:0] {
      KIND_QUAD   = 2'd0,
      KIND_LINEAR = 2'd1,
      KIND_FEW    = 2'd2
   } fit_kind_type;

   typedef struct packed {
      logic             done;
      logic             sat;
      logic [OUT_W-1:0] quot;
   } div_res_type;

endpackage

### sv/lqsf_div.sv
// Restoring divider, one quotient bit per cycle, quotient clamped to the output width.
`timescale 1ns / 1ps
module lqsf_div
   import lqsf_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [WIDE_W-1:0] num,
   input  logic [WIDE_W-1:0] den,
   output div_res_type       res
);

   localparam int CNT_W = $clog2(WIDE_W);

   logic [WIDE_W-1:0] rem_ff;
   logic [WIDE_W-1:0] nq_ff;
   logic [WIDE_W-1:0] den_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic              busy_ff;
   logic              done_ff;
   logic              sat_ff;
   logic [OUT_W-1:0]  quot_ff;

   logic [WIDE_W:0]   rem_sh;
   logic [WIDE_W:0]   rem_diff;
   logic              q_bit;
   logic [WIDE_W-1:0] rem_in;
   logic [WIDE_W-1:0] nq_in;

   always_comb begin
      rem_sh   = {rem_ff, nq_ff[WIDE_W-1]};
      rem_diff = rem_sh - {1'b0, den_ff};
      q_bit    = !rem_diff[WIDE_W];
      rem_in   = q_bit ? rem_diff[WIDE_W-1:0] : rem_sh[WIDE_W-1:0];
      nq_in    = {nq_ff[WIDE_W-2:0], q_bit};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         // one-cycle pulse after the last quotient bit
         done_ff <= busy_ff && !start && (cnt_ff == CNT_W'(WIDE_W - 1));
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
            rem_ff  <= '0;
            nq_ff   <= num;
            den_ff  <= den;
         end else if (busy_ff) begin
            rem_ff <= rem_in;
            nq_ff  <= nq_in;
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(WIDE_W - 1)) begin
               busy_ff <= 1'b0;
               sat_ff  <= |nq_in[WIDE_W-1:OUT_W];
               quot_ff <= (|nq_in[WIDE_W-1:OUT_W]) ? OUT_MAX : nq_in[OUT_W-1:0];
            end
         end
      end
   end

   assign res.done = done_ff;
   assign res.sat  = sat_ff;
   assign res.quot = quot_ff;

endmodule

### sv/linear_quadratic_survival_fit.sv
// Top level: linear-quadratic survival fit, y = alpha*D + beta*D^2 by least squares.
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Each beat on req_ carries a dose (Q5.8 Gy) and a survival fraction (Q0.16,
// 65536 = 1.0). A point with nonzero survival adds D^2, D^3, D^4, D*y and
// D^2*y to running sums, with y = -ln(SF) in Q4.16; survival above 1.0 counts
// as y = 0. Points past MAX_POINTS are ignored. The beat flagged last_point
// starts the fit and yields one rsp_ beat: alpha (Q8.16 /Gy), beta (Q8.16
// /Gy^2), both truncated, clamped at zero and at full scale. With fewer than
// three points the result is marked invalid (kind 2). A near-singular system
// (det below 1e-10) falls back to a pure linear fit (kind 1). All sums clear
// after each fit. The block handles one beat at a time and req_ready is low
// while it works. Everything runs through one registered 32x32 multiplier
// under a small sequencer, and one bit-serial divider. A point with SF zero,
// or beyond MAX_POINTS, needs no product. A point with SF at or above 1.0
// takes the five sum products with y = 0. A point with 0 < SF < 1.0 first
// shifts out k = leading zeros of SF in 17 bits (1..16), then the log takes
// 20 squarings, and the five sum products follow. A fit has a setup step,
// then 64x64 products of four partials each, six products for a full solve
// or two for the linear fallback, at most two divisions, and a load of the
// result register.
// A result waiting on rsp_ holds the block in its output state until taken.
module linear_quadratic_survival_fit
   import lqsf_pkg::*;
#(
   parameter int MAX_POINTS = MAX_POINTS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [DOSE_W-1:0] req_dose,
   input  logic [SF_W-1:0]   req_survival,
   input  logic              req_last_point,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [OUT_W-1:0]  rsp_alpha,
   output logic [OUT_W-1:0]  rsp_beta,
   output logic              rsp_fit_valid,
   output logic [1:0]        rsp_fit_kind,
   output logic              rsp_saturated
);

   localparam int CNT_W = $clog2(MAX_POINTS + 1);
   localparam int D2_W  = 2 * DOSE_W;

   typedef enum logic [3:0] {
      ST_IDLE, ST_NORM, ST_LSQ, ST_LUSE, ST_LN, ST_LNUSE,
      ST_PMUL, ST_PACC, ST_FIT, ST_FMUL, ST_FACC, ST_DIV, ST_OUT
   } state_type;

   state_type         state_ff;

   // point working registers
   logic [CNT_W-1:0]  cnt_ff;
   logic [DOSE_W-1:0] d_ff;
   logic [D2_W-1:0]   d2_ff;
   logic              last_ff;
   logic [SF_W-1:0]   m_ff;
   logic [4:0]        k_ff;
   logic [31:0]       x_ff;
   logic [19:0]       f_ff;
   logic [4:0]        i_ff;
   logic [Y_W-1:0]    y_ff;
   logic [2:0]        j_ff;

   // moment sums
   logic [SUM_W-1:0]  s2_ff, s3_ff, s4_ff, sx_ff, sx2y_ff;

   // fit working registers
   logic [2:0]        tm_ff;
   logic [1:0]        pq_ff;
   logic [WIDE_W-1:0] acc_ff;
   logic [WIDE_W-1:0] det_ff;
   logic [OUT_W-1:0]  wk_alpha_ff, wk_beta_ff;
   logic              wk_valid_ff, wk_sat_ff;
   fit_kind_type      wk_kind_ff;

   // divider handoff
   logic              div_go_ff;
   logic [WIDE_W-1:0] div_num_ff, div_den_ff;
   div_res_type       div_res;
   logic              div_launch;

   // result register
   logic              rsp_valid_ff;
   logic [OUT_W-1:0]  rsp_alpha_ff, rsp_beta_ff;
   logic              rsp_fit_valid_ff, rsp_sat_ff;
   fit_kind_type      rsp_kind_ff;
   logic              out_take;

   // shared multiplier
   logic [31:0]       mul_a, mul_b;
   logic [63:0]       prod_in, prod_ff;

   logic [24:0]       ln_t;
   logic [63:0]       ln_rnd;
   logic [32:0]       sq;
   logic [SUM_W-1:0]  op_a, op_b;
   logic [1:0]        part_sh;
   logic [WIDE_W-1:0] part;
   logic [WIDE_W-1:0] acc_in;

   // log2 integer part minus fraction, scaled 2^20
   assign ln_t   = {k_ff, 20'd0} - {5'd0, f_ff};
   assign ln_rnd = prod_ff + (64'd1 << 35);
   assign sq     = prod_ff[63:31];

   // operand pair of each wide product term; odd terms are subtracted
   always_comb begin
      case (tm_ff)
         3'd0:    begin op_a = s2_ff; op_b = s4_ff;   end
         3'd1:    begin op_a = s3_ff; op_b = s3_ff;   end
         3'd2:    begin op_a = s4_ff; op_b = sx_ff;   end
         3'd3:    begin op_a = s3_ff; op_b = sx2y_ff; end
         3'd4:    begin op_a = s2_ff; op_b = sx2y_ff; end
         3'd5:    begin op_a = s3_ff; op_b = sx_ff;   end
         default: begin op_a = '0;    op_b = '0;      end
      endcase
   end

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         ST_LSQ: begin
            mul_a = x_ff;
            mul_b = x_ff;
         end
         ST_LN: begin
            mul_a = {7'd0, ln_t};
            mul_b = LN2_Q32;
         end
         ST_PMUL: begin
            case (j_ff)
               3'd0:    begin mul_a = 32'(d_ff);  mul_b = 32'(d_ff);  end
               3'd1:    begin mul_a = 32'(d2_ff); mul_b = 32'(d_ff);  end
               3'd2:    begin mul_a = 32'(d2_ff); mul_b = 32'(d2_ff); end
               3'd3:    begin mul_a = 32'(d_ff);  mul_b = 32'(y_ff);  end
               default: begin mul_a = 32'(d2_ff); mul_b = 32'(y_ff);  end
            endcase
         end
         ST_FMUL: begin
            mul_a = pq_ff[1] ? op_a[63:32] : op_a[31:0];
            mul_b = pq_ff[0] ? op_b[63:32] : op_b[31:0];
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod_in = {32'd0, mul_a} * {32'd0, mul_b};

   // partial product placed at 0, 32 or 64 bits
   assign part_sh = {1'b0, pq_ff[1]} + {1'b0, pq_ff[0]};
   assign part    = WIDE_W'(prod_ff) << {part_sh, 5'd0};
   assign acc_in  = tm_ff[0] ? (acc_ff - part) : (acc_ff + part);

   // a division starts after the last partial of a determinant that triggers the
   // fallback with s2 nonzero, or of a non-negative alpha or beta numerator
   assign div_launch = (state_ff == ST_FACC) && (pq_ff == 2'd3) &&
                       (((tm_ff == 3'd1) && (acc_in < DET_EPS) && (s2_ff != '0)) ||
                        (((tm_ff == 3'd3) || (tm_ff == 3'd5)) && !acc_in[WIDE_W-1]));

   // result register loads when empty or being emptied this cycle
   assign out_take = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp_ready);

   lqsf_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_go_ff),
      .num   (div_num_ff),
      .den   (div_den_ff),
      .res   (div_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         s2_ff        <= '0;
         s3_ff        <= '0;
         s4_ff        <= '0;
         sx_ff        <= '0;
         sx2y_ff      <= '0;
         div_go_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         prod_ff      <= prod_in;
         div_go_ff    <= div_launch;
         rsp_valid_ff <= out_take || (rsp_valid_ff && !rsp_ready);

         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  d_ff    <= req_dose;
                  last_ff <= req_last_point;
                  j_ff    <= '0;
                  if (cnt_ff < CNT_W'(MAX_POINTS)) begin
                     cnt_ff <= cnt_ff + 1'b1;
                  end
                  if ((cnt_ff < CNT_W'(MAX_POINTS)) && req_survival[SF_W-1]) begin
                     y_ff     <= '0;
                     state_ff <= ST_PMUL;
                  end else if ((cnt_ff < CNT_W'(MAX_POINTS)) && (req_survival != '0)) begin
                     m_ff     <= req_survival;
                     k_ff     <= '0;
                     state_ff <= ST_NORM;
                  end else begin
                     state_ff <= req_last_point ? ST_FIT : ST_IDLE;
                  end
               end
            end
            ST_NORM: begin
               if (m_ff[SF_W-1]) begin
                  x_ff     <= {m_ff, 15'd0};
                  f_ff     <= '0;
                  i_ff     <= '0;
                  state_ff <= ST_LSQ;
               end else begin
                  m_ff <= {m_ff[SF_W-2:0], 1'b0};
                  k_ff <= k_ff + 1'b1;
               end
            end
            ST_LSQ: begin
               state_ff <= ST_LUSE;
            end
            ST_LUSE: begin
               f_ff <= {f_ff[18:0], sq[32]};
               x_ff <= sq[32] ? sq[32:1] : sq[31:0];
               if (i_ff == 5'd19) begin
                  state_ff <= ST_LN;
               end else begin
                  i_ff     <= i_ff + 1'b1;
                  state_ff <= ST_LSQ;
               end
            end
            ST_LN: begin
               state_ff <= ST_LNUSE;
            end
            ST_LNUSE: begin
               y_ff     <= ln_rnd[55:36];
               state_ff <= ST_PMUL;
            end
            ST_PMUL: begin
               state_ff <= ST_PACC;
            end
            ST_PACC: begin
               case (j_ff)
                  3'd0: begin
                     d2_ff <= prod_ff[D2_W-1:0];
                     s2_ff <= s2_ff + prod_ff;
                  end
                  3'd1:    s3_ff   <= s3_ff + prod_ff;
                  3'd2:    s4_ff   <= s4_ff + prod_ff;
                  3'd3:    sx_ff   <= sx_ff + prod_ff;
                  default: sx2y_ff <= sx2y_ff + prod_ff;
               endcase
               if (j_ff == 3'd4) begin
                  state_ff <= last_ff ? ST_FIT : ST_IDLE;
               end else begin
                  j_ff     <= j_ff + 1'b1;
                  state_ff <= ST_PMUL;
               end
            end
            ST_FIT: begin
               wk_alpha_ff <= '0;
               wk_beta_ff  <= '0;
               wk_sat_ff   <= 1'b0;
               tm_ff       <= '0;
               pq_ff       <= '0;
               acc_ff      <= '0;
               if (cnt_ff < CNT_W'(3)) begin
                  wk_valid_ff <= 1'b0;
                  wk_kind_ff  <= KIND_FEW;
                  state_ff    <= ST_OUT;
               end else begin
                  wk_valid_ff <= 1'b1;
                  wk_kind_ff  <= KIND_QUAD;
                  state_ff    <= ST_FMUL;
               end
            end
            ST_FMUL: begin
               state_ff <= ST_FACC;
            end
            ST_FACC: begin
               pq_ff <= pq_ff + 1'b1;
               if (pq_ff != 2'd3) begin
                  acc_ff   <= acc_in;
                  state_ff <= ST_FMUL;
               end else begin
                  case (tm_ff)
                     3'd1: begin
                        // determinant complete
                        det_ff <= acc_in;
                        acc_ff <= '0;
                        if (acc_in < DET_EPS) begin
                           wk_kind_ff <= KIND_LINEAR;
                           if (s2_ff == '0) begin
                              wk_alpha_ff <= OUT_MAX;
                              wk_sat_ff   <= 1'b1;
                              state_ff    <= ST_OUT;
                           end else begin
                              div_num_ff <= {56'd0, sx_ff, 8'd0};
                              div_den_ff <= WIDE_W'(s2_ff);
                              state_ff   <= ST_DIV;
                           end
                        end else begin
                           tm_ff    <= 3'd2;
                           state_ff <= ST_FMUL;
                        end
                     end
                     3'd3: begin
                        // alpha numerator; negative clamps to zero
                        if (acc_in[WIDE_W-1]) begin
                           tm_ff    <= 3'd4;
                           acc_ff   <= '0;
                           state_ff <= ST_FMUL;
                        end else begin
                           div_num_ff <= acc_in << 8;
                           div_den_ff <= det_ff;
                           state_ff   <= ST_DIV;
                        end
                     end
                     3'd5: begin
                        // beta numerator
                        if (acc_in[WIDE_W-1]) begin
                           state_ff <= ST_OUT;
                        end else begin
                           div_num_ff <= acc_in << 16;
                           div_den_ff <= det_ff;
                           state_ff   <= ST_DIV;
                        end
                     end
                     default: begin
                        acc_ff   <= acc_in;
                        tm_ff    <= tm_ff + 1'b1;
                        state_ff <= ST_FMUL;
                     end
                  endcase
               end
            end
            ST_DIV: begin
               if (div_res.done) begin
                  wk_sat_ff <= wk_sat_ff | div_res.sat;
                  case (tm_ff)
                     3'd3: begin
                        wk_alpha_ff <= div_res.quot;
                        tm_ff       <= 3'd4;
                        acc_ff      <= '0;
                        state_ff    <= ST_FMUL;
                     end
                     3'd5: begin
                        wk_beta_ff <= div_res.quot;
                        state_ff   <= ST_OUT;
                     end
                     default: begin
                        wk_alpha_ff <= div_res.quot;
                        state_ff    <= ST_OUT;
                     end
                  endcase
               end
            end
            ST_OUT: begin
               if (out_take) begin
                  rsp_alpha_ff     <= wk_alpha_ff;
                  rsp_beta_ff      <= wk_beta_ff;
                  rsp_fit_valid_ff <= wk_valid_ff;
                  rsp_kind_ff      <= wk_kind_ff;
                  rsp_sat_ff       <= wk_sat_ff;
                  cnt_ff           <= '0;
                  s2_ff            <= '0;
                  s3_ff            <= '0;
                  s4_ff            <= '0;
                  sx_ff            <= '0;
                  sx2y_ff          <= '0;
                  state_ff         <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign req_ready     = (state_ff == ST_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_alpha     = rsp_alpha_ff;
   assign rsp_beta      = rsp_beta_ff;
   assign rsp_fit_valid = rsp_fit_valid_ff;
   assign rsp_fit_kind  = rsp_kind_ff;
   assign rsp_saturated = rsp_sat_ff;

   // a result beat held back by the receiver stays offered
   `LQSF_ASSERT_NEXT(a_rsp_held, clock, reset, rsp_valid && !rsp_ready, rsp_valid,
      "result beat dropped before it was taken")
   // too few points carries no coefficients
   `LQSF_ASSERT(a_few_points_zero, clock, reset,
      !(rsp_valid && rsp_fit_kind == KIND_FEW) ||
      (!rsp_fit_valid && rsp_alpha == '0 && rsp_beta == '0 && !rsp_saturated),
      "invalid fit carries data")
   // a valid fit is never the too-few-points kind
   `LQSF_ASSERT(a_valid_kind, clock, reset,
      !(rsp_valid && rsp_fit_valid) || (rsp_fit_kind != KIND_FEW),
      "valid fit with too-few kind")
   // saturation always shows as a clamped coefficient
   `LQSF_ASSERT(a_sat_clamped, clock, reset,
      !(rsp_valid && rsp_saturated) || (rsp_alpha == OUT_MAX || rsp_beta == OUT_MAX),
      "saturated without clamped coefficient")

endmodule
